[rtl/core/cqe_pkg.sv]
// Shared types and codes for the circular queue engine.
package cqe_pkg;

   // Operation codes carried in a request
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_LIST   = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Capacity after reset
   localparam int CAP_RESET = 20;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LIST = 2'b10
   } state_type;

endpackage

[rtl/core/cqe_ram.sv]
// Generic single-clock RAM: one write port, one registered read port.
module cqe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/circular_queue_engine.sv]
// Circular queue engine: insert, remove and list over a slot RAM of programmable capacity.
// Results: each result is registered and leaves in the cycle after its request, or for a
//   list, in the cycle after the RAM read of its word; results cannot be stalled, and
//   rsp_valid strobes once per result. Inserts and removes run back to back; a list holds
//   busy high while it walks its remaining words through the one RAM read port.
// Reset: indices clear, the queue reads empty, capacity returns to 20 (bounded by DEPTH).
module circular_queue_engine #(
   parameter int DEPTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            start,
   output logic            busy,
   input  cqe_pkg::req_type req_data,
   // result channel
   output logic            rsp_valid,
   output cqe_pkg::rsp_type rsp_data,
   // capacity register
   input  logic            csr_we,
   input  logic [5:0]      csr_wdata
);

   // Index width covers DEPTH slots; capacity width also holds DEPTH itself and the
   // full six-bit register value.
   localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW      = (IW + 1 > 6) ? IW + 1 : 6;
   localparam int CAP_RST = (cqe_pkg::CAP_RESET > DEPTH) ? DEPTH : cqe_pkg::CAP_RESET;

   // Control state
   cqe_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      head_ff,  head_in;
   logic [IW-1:0]      tail_ff,  tail_in;
   logic [IW-1:0]      ptr_ff,   ptr_in;
   logic               empty_ff, empty_in;
   logic [EW-1:0]      cap_ff,   cap_in;

   // Result register; data comes straight from the RAM's output register when selected
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff,   rsp_last_in;
   logic               rsp_sel_ff,    rsp_sel_in;

   // Slot RAM ports
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [IW-1:0]      rd_addr;
   logic [31:0]        rd_data;

   logic               accept;
   logic [IW-1:0]      nxt_head;
   logic [IW-1:0]      nxt_tail;
   logic [IW-1:0]      nxt_ptr;
   logic [EW-1:0]      cap_wide;
   logic [EW-1:0]      cap_eff;

   // Advance an index, wrapping at the capacity
   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                              input logic [EW-1:0] cap);
      logic [EW-1:0] n;
      n = EW'(idx) + EW'(1);
      return (n >= cap) ? '0 : n[IW-1:0];
   endfunction

   cqe_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff == cqe_pkg::ST_LIST);
   assign accept = start && !busy;

   assign nxt_head = next_idx(head_ff, cap_ff);
   assign nxt_tail = next_idx(tail_ff, cap_ff);
   assign nxt_ptr  = next_idx(ptr_ff,  cap_ff);

   // Clamp a written capacity into 1 .. DEPTH
   always_comb begin
      cap_wide = EW'(csr_wdata);
      if (cap_wide == '0) begin
         cap_eff = EW'(1);
      end else if (cap_wide > EW'(DEPTH)) begin
         cap_eff = EW'(DEPTH);
      end else begin
         cap_eff = cap_wide;
      end
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      ptr_in        = ptr_ff;
      empty_in      = empty_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_sel_in    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;
      wr_data       = req_data.data_in;
      rd_addr       = head_ff;

      unique case (state_ff)
         cqe_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.func)
                  cqe_pkg::FUNC_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (empty_ff) begin
                        // restart at slot zero
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        head_in       = '0;
                        tail_in       = '0;
                        empty_in      = 1'b0;
                        rsp_status_in = cqe_pkg::STATUS_OK;
                     end else if (nxt_tail == head_ff) begin
                        rsp_status_in = cqe_pkg::STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = nxt_tail;
                        tail_in       = nxt_tail;
                        rsp_status_in = cqe_pkg::STATUS_OK;
                     end
                  end
                  cqe_pkg::FUNC_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (empty_ff) begin
                        rsp_status_in = cqe_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_status_in = cqe_pkg::STATUS_OK;
                        rsp_sel_in    = 1'b1;
                        if (head_ff == tail_ff) begin
                           // drop the final word and restart at slot zero
                           head_in  = '0;
                           tail_in  = '0;
                           empty_in = 1'b1;
                        end else begin
                           head_in = nxt_head;
                        end
                     end
                  end
                  cqe_pkg::FUNC_LIST: begin
                     rsp_valid_in = 1'b1;
                     if (empty_ff) begin
                        rsp_status_in = cqe_pkg::STATUS_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        rsp_status_in = cqe_pkg::STATUS_OK;
                        rsp_sel_in    = 1'b1;
                        rsp_last_in   = (head_ff == tail_ff);
                        if (head_ff != tail_ff) begin
                           // walk the remaining words one read per cycle
                           state_in = cqe_pkg::ST_LIST;
                           ptr_in   = nxt_head;
                        end
                     end
                  end
                  default: begin
                     // unused code: no result, no change
                  end
               endcase
            end
         end
         cqe_pkg::ST_LIST: begin
            rd_addr       = ptr_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = cqe_pkg::STATUS_OK;
            rsp_sel_in    = 1'b1;
            rsp_last_in   = (ptr_ff == tail_ff);
            if (ptr_ff == tail_ff) begin
               state_in = cqe_pkg::ST_IDLE;
            end else begin
               ptr_in = nxt_ptr;
            end
         end
         default: begin
            state_in = cqe_pkg::ST_IDLE;
         end
      endcase

      // A capacity write empties the queue
      if (csr_we) begin
         cap_in   = cap_eff;
         head_in  = '0;
         tail_in  = '0;
         empty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cqe_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         ptr_ff       <= '0;
         empty_ff     <= 1'b1;
         cap_ff       <= EW'(CAP_RST);
         rsp_valid_ff <= 1'b0;
         rsp_sel_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ptr_ff       <= ptr_in;
         empty_ff     <= empty_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_sel_ff   <= rsp_sel_in;
      end
   end

   // Payload of the result register: no reset
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.status   = rsp_status_ff;
   assign rsp_data.data_out = rsp_sel_ff ? rd_data : '0;
   assign rsp_data.last     = rsp_last_ff;

endmodule

[tb/queue_checker.sv]
`timescale 1ns / 100ps
// Request/result monitor for the circular queue engine: predicts every result and compares it.
module queue_checker
   import cqe_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [5:0] csr_wdata,
   output int         mismatches,
   output int         pending
);

   logic signed [31:0] slot_words [DEPTH];
   int unsigned        head_slot;
   int unsigned        tail_slot;
   bit                 queue_empty;
   logic [5:0]         capacity_reg;
   rsp_type            awaited_results [$];
   int                 result_count;

   function automatic int unsigned wrap_point();
      int unsigned c;
      c = 32'(capacity_reg);
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic int unsigned next_slot(int unsigned i);
      return (i + 1 >= wrap_point()) ? 0 : i + 1;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t queue_checker: %s", $time, msg);
      mismatches++;
   endtask

   task automatic await_result(logic [1:0] st, logic signed [31:0] word, logic fin);
      rsp_type r;
      r.status   = st;
      r.data_out = word;
      r.last     = fin;
      awaited_results.push_back(r);
   endtask

   task automatic clear_queue();
      head_slot   = 0;
      tail_slot   = 0;
      queue_empty = 1'b1;
   endtask

   // Work out the results of one accepted request and advance the queue state.
   task automatic apply_request(req_type r);
      int unsigned nt;
      int unsigned i;
      logic signed [31:0] word;
      bit fin;
      case (r.func)
         FUNC_INSERT: begin
            if (queue_empty) begin
               clear_queue();
               slot_words[0] = r.data_in;
               queue_empty   = 1'b0;
               await_result(STATUS_OK, '0, 1'b1);
            end else begin
               nt = next_slot(tail_slot);
               if (nt == head_slot) begin
                  await_result(STATUS_FULL, '0, 1'b1);
               end else begin
                  tail_slot         = nt;
                  slot_words[nt]    = r.data_in;
                  await_result(STATUS_OK, '0, 1'b1);
               end
            end
         end
         FUNC_REMOVE: begin
            if (queue_empty) begin
               await_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               word = slot_words[head_slot];
               if (head_slot == tail_slot) clear_queue();
               else head_slot = next_slot(head_slot);
               await_result(STATUS_OK, word, 1'b1);
            end
         end
         FUNC_LIST: begin
            if (queue_empty) begin
               await_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               i = head_slot;
               for (int n = 0; n < DEPTH; n++) begin
                  fin = (i == tail_slot) || (n == DEPTH - 1);
                  await_result(STATUS_OK, slot_words[i], fin);
                  if (fin) break;
                  i = next_slot(i);
               end
            end
         end
         default: ; // unused code: no result, no state change
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         awaited_results.delete();
         capacity_reg = 6'(CAP_RESET);
         clear_queue();
      end else begin
         // results always belong to requests accepted at earlier edges, so compare first
         if (rsp_valid) begin
            result_count++;
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing awaited", result_count));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("result %0d status %0d, wanted %0d",
                                            result_count, rsp_data.status, want.status));
               if (rsp_data.data_out !== want.data_out)
                  report_mismatch($sformatf("result %0d data_out %h, wanted %h",
                                            result_count, rsp_data.data_out, want.data_out));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("result %0d last %b, wanted %b",
                                            result_count, rsp_data.last, want.last));
            end
         end
         if (csr_we) begin
            capacity_reg = csr_wdata;
            clear_queue();
         end
         if (start && !busy) apply_request(req_data);
      end
      pending <= awaited_results.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top-level testbench for the circular queue engine: clock, reset, request stimulus and verdict.
module tb_top;
   import cqe_pkg::*;

   localparam int DEPTH       = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int FILL        = 0;
   localparam int DRAIN       = 1;
   localparam int MIXED       = 2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [5:0] csr_wdata;
   int         mismatch_count;
   int         pending_results;
   int         cycle_count;

   // Drive every input to a known value before the first edge.
   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
   end

   always #4 clock = ~clock;

   circular_queue_engine #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   queue_checker #(
      .DEPTH(DEPTH)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatch_count),
      .pending    (pending_results)
   );

   // Watchdog: abandon the run if the engine stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Present one request and hold it until an edge sees start high with busy low.
   task automatic send_request(logic [1:0] op, logic signed [31:0] word);
      req_type r;
      r.func    = op;
      r.data_in = word;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a random gap: mostly none or short, now and then long.
   task automatic pause_requests();
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      if (roll < 45) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         start    <= 1'b0;
         req_data <= {2'($urandom_range(0, 3)), $urandom()};  // junk while idle
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lower start and wait until every awaited result is in; then let an
   // ignored request that is still in flight settle.
   task automatic wait_for_quiet();
      start <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write the capacity only while the engine is idle; the write also empties the queue.
   task automatic set_capacity(logic [5:0] value);
      wait_for_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Choose an operation with a bias that fills, drains or churns the queue.
   function automatic logic [1:0] pick_op(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         FILL: begin
            if (roll < 88) return FUNC_INSERT;
            if (roll < 94) return FUNC_REMOVE;
            if (roll < 99) return FUNC_LIST;
         end
         DRAIN: begin
            if (roll < 15) return FUNC_INSERT;
            if (roll < 85) return FUNC_REMOVE;
            if (roll < 98) return FUNC_LIST;
         end
         default: begin
            if (roll < 45) return FUNC_INSERT;
            if (roll < 80) return FUNC_REMOVE;
            if (roll < 97) return FUNC_LIST;
         end
      endcase
      return FUNC_UNUSED;  // unused code, engine must ignore it
   endfunction

   initial begin
      logic [5:0] phase_caps [6];
      int         phase_lens [6];
      int         mode;
      int         seg_left;
      bit         back_to_back;

      // Hold reset, then release.
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, field extremes, list, ignored code, drain to empty.
      send_request(FUNC_REMOVE, 32'sh0000_0000);
      send_request(FUNC_LIST,   32'sh0000_0000);
      send_request(FUNC_INSERT, 32'sh7FFF_FFFF);
      send_request(FUNC_INSERT, 32'sh8000_0000);
      send_request(FUNC_INSERT, 32'sh0000_0000);
      send_request(FUNC_INSERT, -32'sd1);
      send_request(FUNC_LIST,   -32'sd1);
      send_request(FUNC_REMOVE, 32'sh5555_AAAA);
      send_request(FUNC_UNUSED, 32'shFFFF_FFFF);
      send_request(FUNC_REMOVE, 32'sh0000_0000);
      send_request(FUNC_REMOVE, 32'sh0000_0000);
      send_request(FUNC_REMOVE, 32'sh0000_0000);
      send_request(FUNC_LIST,   32'sh0000_0000);

      // Two slots: empty the queue from the final slot, then refill to full.
      set_capacity(6'd2);
      send_request(FUNC_INSERT, 32'sh1234_5678);
      send_request(FUNC_INSERT, 32'shDEAD_BEEF);
      send_request(FUNC_REMOVE, 32'sh0000_0000);
      send_request(FUNC_REMOVE, 32'sh0000_0000);
      send_request(FUNC_INSERT, 32'sh0F0F_0F0F);
      send_request(FUNC_INSERT, 32'shF0F0_F0F0);
      send_request(FUNC_INSERT, 32'sh7777_7777);
      send_request(FUNC_LIST,   32'sh0000_0000);
      send_request(FUNC_REMOVE, 32'sh0000_0000);

      // Random phases, each under its own capacity; zero and 63 test the clamps.
      phase_caps = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd0, 6'd0};
      phase_caps[4] = 6'($urandom_range(3, 31));
      phase_caps[5] = 6'($urandom_range(2, 8));
      phase_lens = '{50, 30, 40, 30, 40, 40};
      for (int p = 0; p < 6; p++) begin
         set_capacity(phase_caps[p]);
         back_to_back = (p == 2);  // one phase with no idling at all
         seg_left = 0;
         for (int k = 0; k < phase_lens[p]; k++) begin
            if (seg_left == 0) begin
               // open each phase by filling; the first fill at full depth wraps all slots
               mode     = (k == 0) ? FILL : $urandom_range(FILL, MIXED);
               seg_left = (p == 0 && k == 0) ? 42 : $urandom_range(8, 20);
            end
            seg_left--;
            send_request(pick_op(mode), $urandom());
            if (!back_to_back) pause_requests();
         end
      end

      // Drain, then give any stray result time to show up.
      wait_for_quiet();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/cqe_pkg.sv
rtl/core/cqe_ram.sv
rtl/core/circular_queue_engine.sv
tb/queue_checker.sv
tb/tb_top.sv
